// ===== sv/duration_stats_table_assert.svh =====
// Assertion macros shared by the duration statistics table RTL.
`ifndef DURATION_STATS_TABLE_ASSERT_SVH
`define DURATION_STATS_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/dst_pkg.sv =====
`timescale 1ns / 1ps

package dst_pkg;

	localparam int ENTRIES_DEF  = 16;
	localparam int KEY_BITS_DEF = 32;

	localparam int OP_W     = 1;
	localparam int SKEY_W   = 32;
	localparam int TIME_W   = 64;
	localparam int IDX_W    = 4;
	localparam int STATUS_W = 2;
	localparam int USED_W   = 5;
	localparam int CNT_W    = 32;

	typedef enum logic [OP_W-1:0] {
		OP_RECORD = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Operands of the shared add/subtract unit
	typedef struct packed {
		logic [TIME_W-1:0] a;
		logic [TIME_W-1:0] b;
		logic              sub;
	} alu_req_t;

	typedef struct packed {
		logic [TIME_W-1:0] res;
		logic              borrow;
	} alu_rsp_t;

endpackage

// ===== sv/dst_cmd_if.sv =====
`timescale 1ns / 1ps

interface dst_cmd_if;
	import dst_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [SKEY_W-1:0]   scope_key;
	logic [TIME_W-1:0]   start_time;
	logic [TIME_W-1:0]   end_time;
	logic [IDX_W-1:0]    entry_index;

	modport source (output valid, op, scope_key, start_time, end_time, entry_index,
		input ready);
	modport sink (input valid, op, scope_key, start_time, end_time, entry_index,
		output ready);
endinterface

// ===== sv/dst_rsp_if.sv =====
`timescale 1ns / 1ps

interface dst_rsp_if;
	import dst_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [USED_W-1:0]   entries_used;
	logic [SKEY_W-1:0]   entry_key;
	logic [CNT_W-1:0]    entry_count;
	logic [TIME_W-1:0]   entry_total;
	logic [TIME_W-1:0]   entry_min;
	logic [TIME_W-1:0]   entry_max;

	modport source (output valid, status, entries_used, entry_key, entry_count,
		entry_total, entry_min, entry_max, input ready);
	modport sink (input valid, status, entries_used, entry_key, entry_count,
		entry_total, entry_min, entry_max, output ready);
endinterface

// ===== sv/duration_stats_table.sv =====
`timescale 1ns / 1ps

// Channel  Modport  Item
// -------  -------  -----------------------------------------------------------
// cmd      sink     op, scope_key, start_time, end_time, entry_index
// rsp      source   status, entries_used, entry_key, entry_count, entry_total,
//                   entry_min, entry_max
//
// One item at a time. Record: INVALID for an empty key or a reversed span,
// else find or add the key (FULL if absent and the table is full), then update
// its count, total, minimum and maximum. Read: NOT_FOUND for an index past the
// used entries, else the entry. The key search reads one table entry per cycle
// from the single-port table, and one shared 64-bit add/subtract unit does the
// elapsed, total, minimum and maximum steps.
// Reset clears the used count at once; no clearing pass. A result waits in the
// output register while rsp is stalled and the next item is already taken.

module duration_stats_table #(
	parameter int ENTRIES  = dst_pkg::ENTRIES_DEF,
	parameter int KEY_BITS = dst_pkg::KEY_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	dst_cmd_if.sink     cmd,
	dst_rsp_if.source   rsp
);
	import dst_pkg::*;

	`include "duration_stats_table_assert.svh"

	localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int UW   = $clog2(ENTRIES + 1);
	localparam int CMPW = (UW > IDX_W) ? UW : IDX_W;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [CNT_W-1:0]    cnt;
		logic [TIME_W-1:0]   tot;
		logic [TIME_W-1:0]   mn;
		logic [TIME_W-1:0]   mx;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_SCAN, S_ADD, S_MIN, S_MAX, S_RDCHK, S_RDW, S_EMIT
	} state_t;

	state_t              state_q;
	logic [KEY_BITS-1:0] key_q;
	logic [TIME_W-1:0]   t0_q;
	logic [TIME_W-1:0]   t1_q;
	logic [TIME_W-1:0]   elap_q;
	logic [IDX_W-1:0]    idx_q;
	logic [UW-1:0]       used_q;
	logic [UW-1:0]       scan_q;
	logic                cmp_v_q;
	logic [AW-1:0]       cmp_idx_q;
	logic [AW-1:0]       slot_q;
	entry_t              base_q;
	entry_t              rd_q;
	status_t             res_st_q;
	logic                res_show_q;

	logic                out_v_q;
	status_t             out_st_q;
	logic [USED_W-1:0]   out_used_q;
	logic [SKEY_W-1:0]   out_key_q;
	logic [CNT_W-1:0]    out_cnt_q;
	logic [TIME_W-1:0]   out_tot_q;
	logic [TIME_W-1:0]   out_min_q;
	logic [TIME_W-1:0]   out_max_q;

	entry_t              mem [ENTRIES];

	alu_req_t            alu_req;
	alu_rsp_t            alu_rsp;
	logic                hit;
	logic                more;
	logic                idx_ok;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	entry_t              wr_data;

	dst_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign hit    = cmp_v_q && (rd_q.key == key_q);
	assign more   = scan_q < used_q;
	assign idx_ok = CMPW'(idx_q) < CMPW'(used_q);

	always_comb begin
		unique case (state_q)
			S_ADD: begin
				alu_req = '{a: base_q.tot, b: elap_q, sub: 1'b0};
			end
			S_MIN: begin
				alu_req = '{a: elap_q, b: base_q.mn, sub: 1'b1};
			end
			S_MAX: begin
				alu_req = '{a: base_q.mx, b: elap_q, sub: 1'b1};
			end
			default: begin
				alu_req = '{a: t1_q, b: t0_q, sub: 1'b1};
			end
		endcase
	end

	always_comb begin
		rd_en   = ((state_q == S_SCAN) && !hit && more) || ((state_q == S_RDCHK) && idx_ok);
		rd_addr = (state_q == S_SCAN) ? AW'(scan_q) : AW'(idx_q);
		wr_en   = state_q == S_MAX;
		wr_data = base_q;
		if (alu_rsp.borrow) begin
			wr_data.mx = elap_q;
		end
	end

	// Table: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[slot_q] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign cmd.ready        = state_q == S_IDLE;
	assign rsp.valid        = out_v_q;
	assign rsp.status       = out_st_q;
	assign rsp.entries_used = out_used_q;
	assign rsp.entry_key    = out_key_q;
	assign rsp.entry_count  = out_cnt_q;
	assign rsp.entry_total  = out_tot_q;
	assign rsp.entry_min    = out_min_q;
	assign rsp.entry_max    = out_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			key_q      <= '0;
			t0_q       <= '0;
			t1_q       <= '0;
			elap_q     <= '0;
			idx_q      <= '0;
			used_q     <= '0;
			scan_q     <= '0;
			cmp_v_q    <= 1'b0;
			cmp_idx_q  <= '0;
			slot_q     <= '0;
			base_q     <= '0;
			res_st_q   <= ST_OK;
			res_show_q <= 1'b0;
			out_v_q    <= 1'b0;
			out_st_q   <= ST_OK;
			out_used_q <= '0;
			out_key_q  <= '0;
			out_cnt_q  <= '0;
			out_tot_q  <= '0;
			out_min_q  <= '0;
			out_max_q  <= '0;
		end else begin
			// Load the output register once it is free, else drop a taken item
			if ((state_q == S_EMIT) && (!out_v_q || rsp.ready)) begin
				out_v_q    <= 1'b1;
				out_st_q   <= res_st_q;
				out_used_q <= USED_W'(used_q);
				out_key_q  <= res_show_q ? SKEY_W'(rd_q.key) : '0;
				out_cnt_q  <= res_show_q ? rd_q.cnt : '0;
				out_tot_q  <= res_show_q ? rd_q.tot : '0;
				out_min_q  <= res_show_q ? rd_q.mn : '0;
				out_max_q  <= res_show_q ? rd_q.mx : '0;
			end else if (out_v_q && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						key_q <= KEY_BITS'(cmd.scope_key);
						t0_q  <= cmd.start_time;
						t1_q  <= cmd.end_time;
						idx_q <= cmd.entry_index;
						state_q <= (cmd.op == OP_READ) ? S_RDCHK : S_CHECK;
					end
				end
				S_CHECK: begin
					res_show_q <= 1'b0;
					if ((key_q == '0) || alu_rsp.borrow) begin
						res_st_q <= ST_INVALID;
						state_q  <= S_EMIT;
					end else begin
						elap_q  <= alu_rsp.res;
						scan_q  <= '0;
						cmp_v_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// Issue one read per cycle, compare the previous one
					if (hit) begin
						slot_q  <= cmp_idx_q;
						base_q  <= rd_q;
						cmp_v_q <= 1'b0;
						state_q <= S_ADD;
					end else if (more) begin
						cmp_v_q   <= 1'b1;
						cmp_idx_q <= AW'(scan_q);
						scan_q    <= scan_q + 1'b1;
					end else if (used_q == UW'(ENTRIES)) begin
						cmp_v_q  <= 1'b0;
						res_st_q <= ST_FULL;
						state_q  <= S_EMIT;
					end else begin
						cmp_v_q    <= 1'b0;
						slot_q     <= AW'(used_q);
						used_q     <= used_q + 1'b1;
						base_q.key <= key_q;
						base_q.cnt <= '0;
						base_q.tot <= '0;
						base_q.mn  <= elap_q;
						base_q.mx  <= '0;
						state_q    <= S_ADD;
					end
				end
				S_ADD: begin
					if (base_q.cnt != '1) begin
						base_q.cnt <= base_q.cnt + 1'b1;
					end
					base_q.tot <= alu_rsp.res;
					state_q    <= S_MIN;
				end
				S_MIN: begin
					if (alu_rsp.borrow) begin
						base_q.mn <= elap_q;
					end
					state_q <= S_MAX;
				end
				S_MAX: begin
					res_st_q <= ST_OK;
					state_q  <= S_EMIT;
				end
				S_RDCHK: begin
					if (idx_ok) begin
						state_q <= S_RDW;
					end else begin
						res_st_q   <= ST_NOT_FOUND;
						res_show_q <= 1'b0;
						state_q    <= S_EMIT;
					end
				end
				S_RDW: begin
					res_st_q   <= ST_OK;
					res_show_q <= 1'b1;
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					// Hold until the output register is free
					if (!out_v_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`DST_ASSERT_IMP(a_used_bound, clk, arst_n, 1'b1, used_q <= UW'(ENTRIES), "used count above capacity")
	`DST_ASSERT_NXT(a_used_step, clk, arst_n, 1'b1, (used_q == $past(used_q)) || (used_q == $past(used_q) + 1'b1), "used count moved by more than one")
	`DST_ASSERT_IMP(a_slot_in_use, clk, arst_n, (state_q == S_ADD) || (state_q == S_MIN) || (state_q == S_MAX), slot_q < used_q, "update slot outside used entries")
	`DST_ASSERT_IMP(a_nf_zero, clk, arst_n, out_v_q && (out_st_q != ST_OK), (out_cnt_q == '0) && (out_key_q == '0) && (out_max_q == '0), "entry fields set on a failed item")
endmodule

// ===== sv/dst_alu.sv =====
`timescale 1ns / 1ps

module dst_alu (
	input  dst_pkg::alu_req_t req,
	output dst_pkg::alu_rsp_t rsp
);
	import dst_pkg::*;

	logic [TIME_W:0] sum;

	// Subtract as a + ~b + 1; a clear carry out means a < b
	assign sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
		+ {{TIME_W{1'b0}}, req.sub};
	assign rsp.res    = sum[TIME_W-1:0];
	assign rsp.borrow = req.sub & ~sum[TIME_W];
endmodule
